// ----- rtl/cdh_pkg.sv -----
// Shared types, constants and the phase table for the candidate descriptor hasher.
package cdh_pkg;

  localparam int OPS_PER_CELL = 64;
  localparam int THREAD_LIMIT = 64;
  localparam int MIX_ROUNDS   = 9;

  localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FIELD = 2'd1,
    ST_ADDR  = 2'd2,
    ST_CTRL  = 2'd3
  } cdh_status_t;

  // Result fields plus the words still to be folded into the identity.
  typedef struct packed {
    cdh_status_t                 status;
    logic [18:0]                 proj;
    logic [5:0]                  phase;
    logic [7:0]                  trits;
    logic [MIX_ROUNDS-1:0][63:0] word;
  } cdh_side_t;

  localparam logic [5:0] PHASE_ROM [0:63] = '{
    6'd0,  6'd0,  6'd36, 6'd0,  6'd54, 6'd0,  6'd54, 6'd18,
    6'd36, 6'd36, 6'd18, 6'd18, 6'd36, 6'd54, 6'd54, 6'd54,
    6'd54, 6'd54, 6'd36, 6'd36, 6'd54, 6'd36, 6'd18, 6'd54,
    6'd54, 6'd0,  6'd36, 6'd0,  6'd18, 6'd36, 6'd36, 6'd0,
    6'd54, 6'd0,  6'd0,  6'd0,  6'd54, 6'd36, 6'd18, 6'd18,
    6'd0,  6'd18, 6'd54, 6'd36, 6'd18, 6'd18, 6'd0,  6'd18,
    6'd0,  6'd36, 6'd36, 6'd54, 6'd18, 6'd18, 6'd54, 6'd36,
    6'd36, 6'd18, 6'd18, 6'd0,  6'd36, 6'd54, 6'd18, 6'd36
  };

  function automatic int cdh_pow3(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = r * 3;
    end
    return r;
  endfunction

endpackage

// ----- rtl/cdh_mix_round.sv -----
// One splitmix64 finalizer round as four register stages with split 64-bit multiplies.
module cdh_mix_round (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       ident_in,
  input  logic [63:0]       mix_word,
  input  cdh_pkg::cdh_side_t side_in,
  output logic              out_valid,
  output logic [63:0]       ident_out,
  output cdh_pkg::cdh_side_t side_out
);
  import cdh_pkg::*;

  logic        valid_a, valid_b, valid_c, valid_d;
  logic [63:0] a_ll, c_ll;
  logic [31:0] a_lh, a_hl, c_lh, c_hl;
  logic [63:0] b_u, d_ident;
  cdh_side_t   side_a, side_b, side_c, side_d;

  logic [63:0] x, v, p, u, q, r;

  always_comb begin
    x = ident_in ^ mix_word;
    v = x ^ (x >> 30);
    p = a_ll + {a_lh + a_hl, 32'b0};
    u = p ^ (p >> 27);
    q = c_ll + {c_lh + c_hl, 32'b0};
    r = q ^ (q >> 31);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      valid_c <= 1'b0;
      valid_d <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
      valid_c <= valid_b;
      valid_d <= valid_c;
    end
  end

  // partial products: low x low full, cross terms low half only
  always_ff @(posedge clk) begin
    if (en) begin
      a_ll    <= v[31:0] * MIX_MUL_A[31:0];
      a_lh    <= v[31:0] * MIX_MUL_A[63:32];
      a_hl    <= v[63:32] * MIX_MUL_A[31:0];
      side_a  <= side_in;
      b_u     <= u;
      side_b  <= side_a;
      c_ll    <= b_u[31:0] * MIX_MUL_B[31:0];
      c_lh    <= b_u[31:0] * MIX_MUL_B[63:32];
      c_hl    <= b_u[63:32] * MIX_MUL_B[31:0];
      side_c  <= side_b;
      d_ident <= r;
      side_d  <= side_c;
    end
  end

  assign out_valid = valid_d;
  assign ident_out = d_ident;
  assign side_out  = side_d;

endmodule

// ----- rtl/candidate_descriptor_hasher_core.sv -----
// Top level of the candidate descriptor hasher: field checks, address and trits, identity chain.
//
// Usage:
//   Input channel (in_valid / in_stall): one transaction candidate per transfer.
//   Output channel (out_valid / out_stall): one descriptor per candidate, in order.
//   Each candidate is checked (thread id, write cell, write value, then machine state,
//   then control word) and the first failing check sets status; on failure all other
//   result fields read zero.
// Depth: 37 register stages. One input register stage, then nine mix rounds of four
//   stages each. Each round splits its two 64-bit multiplies into 32-bit partial
//   products with an add stage behind them; that sets the depth.
// Throughput: one candidate per cycle when not stalled; no state is kept between candidates.
// Stall: the whole pipeline advances on one enable, held only while a result sits in
//   the output register and out_stall is high. in_stall is the inverse of that enable,
//   so nothing is dropped or repeated and a stalled result holds its value.
// Reset: rst (synchronous) clears all stage valid bits and holds in_stall high;
//   payload registers are not reset.
module candidate_descriptor_hasher_core #(
  parameter int CELL_COUNT = 81,
  parameter int TRIT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [63:0]       epoch,
  input  logic [31:0]       sequence_req,
  input  logic [7:0]        issuer_tid,
  input  logic [15:0]       machine_state,
  input  logic [15:0]       control_word,
  input  logic [7:0]        wr_cell,
  input  logic signed [7:0] wr_val,
  input  logic [63:0]       instruction_id,
  input  logic [63:0]       read_set_low,
  input  logic [63:0]       read_set_high,
  input  logic [63:0]       write_set_low,
  input  logic [63:0]       write_set_high,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [18:0]       proj_addr,
  output logic [5:0]        phase,
  output logic [7:0]        ctrl_digits,
  output logic [63:0]       cand_hash
);
  import cdh_pkg::*;

  localparam int SPAN        = cdh_pow3(TRIT_COUNT);
  localparam int STATE_LIMIT = CELL_COUNT * OPS_PER_CELL;
  localparam int KEPT_TRITS  = (TRIT_COUNT < 4) ? TRIT_COUNT : 4;

  // global pipeline advance
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = rst || !en;

  // input register stage
  logic              s0_valid;
  logic [63:0]       s0_epoch, s0_instr;
  logic [31:0]       s0_seq;
  logic [7:0]        s0_tid, s0_wcell, s0_wval;
  logic [15:0]       s0_state, s0_ctl;
  logic [63:0]       s0_read_x, s0_write_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  // each bitmap's low and high words only ever appear XORed together
  always_ff @(posedge clk) begin
    if (en) begin
      s0_epoch   <= epoch;
      s0_seq     <= sequence_req;
      s0_tid     <= issuer_tid;
      s0_state   <= machine_state;
      s0_ctl     <= control_word;
      s0_wcell   <= wr_cell;
      s0_wval    <= wr_val;
      s0_instr   <= instruction_id;
      s0_read_x  <= read_set_low ^ read_set_high;
      s0_write_x <= write_set_low ^ write_set_high;
    end
  end

  // checks, address, phase, trits; these ride along beside the mix chain
  logic        valid_k [0:MIX_ROUNDS];
  logic [63:0] ident_k [0:MIX_ROUNDS];
  cdh_side_t   side_k  [0:MIX_ROUNDS];
  cdh_side_t   side0;

  logic        field_ok;
  logic [33:0] proj_full;
  logic [15:0] rem;
  logic [16:0] pw;
  logic [1:0]  digit;
  logic [7:0]  trits;
  cdh_status_t st_code;

  always_comb begin
    field_ok = (s0_tid < 8'(THREAD_LIMIT)) &&
               ({1'b0, s0_wcell} < 9'(CELL_COUNT)) &&
               (s0_wval == 8'hFF || s0_wval == 8'h00 || s0_wval == 8'h01);
    if (!field_ok) begin
      st_code = ST_FIELD;
    end else if ({1'b0, s0_state} >= 17'(STATE_LIMIT)) begin
      st_code = ST_ADDR;
    end else if ({1'b0, s0_ctl} >= 17'(SPAN)) begin
      st_code = ST_CTRL;
    end else begin
      st_code = ST_OK;
    end

    proj_full = 34'(s0_state) * 34'(SPAN) + 34'(s0_ctl);

    // top digits only, most significant first; greedy compare/subtract per digit
    rem   = s0_ctl;
    trits = '0;
    pw    = '0;
    digit = '0;
    for (int i = 0; i < KEPT_TRITS; i++) begin
      pw = 17'(cdh_pow3(TRIT_COUNT - 1 - i));
      if ({1'b0, rem} >= (pw << 1)) begin
        digit = 2'd2;
      end else if ({1'b0, rem} >= pw) begin
        digit = 2'd1;
      end else begin
        digit = 2'd0;
      end
      rem = rem - 16'(pw * 17'(digit));
      trits[2*i +: 2] = digit;
    end

    side0.status = st_code;
    if (st_code == ST_OK) begin
      side0.proj  = proj_full[18:0];
      side0.phase = PHASE_ROM[s0_state[5:0]];
      side0.trits = trits;
    end else begin
      side0.proj  = '0;
      side0.phase = '0;
      side0.trits = '0;
    end

    side0.word[0] = {s0_seq, 32'b0};
    side0.word[1] = {s0_tid, 56'b0} >> 8;
    side0.word[2] = {32'b0, s0_state, 16'b0};
    side0.word[3] = {40'b0, s0_ctl, 8'b0};
    side0.word[4] = {55'b0, s0_wcell, 1'b0};
    side0.word[5] = {56'b0, s0_wval + 8'd1};
    side0.word[6] = s0_instr;
    side0.word[7] = s0_read_x;
    side0.word[8] = s0_write_x;
  end

  assign side_k[0]  = side0;
  assign valid_k[0] = s0_valid;
  assign ident_k[0] = s0_epoch;

  // identity chain: one finalizer round per folded word
  for (genvar k = 0; k < MIX_ROUNDS; k++) begin : g_round
    cdh_mix_round u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (valid_k[k]),
      .ident_in (ident_k[k]),
      .mix_word (side_k[k].word[k]),
      .side_in  (side_k[k]),
      .out_valid(valid_k[k+1]),
      .ident_out(ident_k[k+1]),
      .side_out (side_k[k+1])
    );
  end

  // last round's registers are the output register
  assign out_valid   = valid_k[MIX_ROUNDS];
  assign status      = side_k[MIX_ROUNDS].status;
  assign proj_addr   = side_k[MIX_ROUNDS].proj;
  assign phase       = side_k[MIX_ROUNDS].phase;
  assign ctrl_digits = side_k[MIX_ROUNDS].trits;
  assign cand_hash   = (side_k[MIX_ROUNDS].status == ST_OK) ?
                       ident_k[MIX_ROUNDS] : 64'b0;

endmodule

// ----- dv/candidate_descriptor_hasher_core_tb.sv -----
// Self-checking testbench for the candidate descriptor hasher core.
module candidate_descriptor_hasher_core_tb;
  import cdh_pkg::*;

  // Block configuration under test; the predictor works from the same values.
  localparam int CELLS       = 81;
  localparam int TRITS       = 4;
  localparam int CTRL_SPAN   = 81;                  // 3^TRITS
  localparam int STATE_SPAN  = CELLS * OPS_PER_CELL;
  localparam int LATENCY     = 37;
  localparam int CYCLE_LIMIT = 200000;

  // Operation phase by (state mod 64).
  localparam logic [5:0] OP_PHASE [0:63] = '{
    6'd0,  6'd0,  6'd36, 6'd0,  6'd54, 6'd0,  6'd54, 6'd18,
    6'd36, 6'd36, 6'd18, 6'd18, 6'd36, 6'd54, 6'd54, 6'd54,
    6'd54, 6'd54, 6'd36, 6'd36, 6'd54, 6'd36, 6'd18, 6'd54,
    6'd54, 6'd0,  6'd36, 6'd0,  6'd18, 6'd36, 6'd36, 6'd0,
    6'd54, 6'd0,  6'd0,  6'd0,  6'd54, 6'd36, 6'd18, 6'd18,
    6'd0,  6'd18, 6'd54, 6'd36, 6'd18, 6'd18, 6'd0,  6'd18,
    6'd0,  6'd36, 6'd36, 6'd54, 6'd18, 6'd18, 6'd54, 6'd36,
    6'd36, 6'd18, 6'd18, 6'd0,  6'd36, 6'd54, 6'd18, 6'd36
  };

  typedef struct packed {
    logic [63:0] epoch;
    logic [31:0] sequence_req;
    logic [7:0]  issuer_tid;
    logic [15:0] machine_state;
    logic [15:0] control_word;
    logic [7:0]  wr_cell;
    logic [7:0]  wr_val;          // raw two's complement bits
    logic [63:0] instruction_id;
    logic [63:0] read_set_low;
    logic [63:0] read_set_high;
    logic [63:0] write_set_low;
    logic [63:0] write_set_high;
  } candidate_t;

  typedef struct packed {
    cdh_status_t status;
    logic [18:0] proj_addr;
    logic [5:0]  phase;
    logic [7:0]  ctrl_digits;
    logic [63:0] cand_hash;
  } descriptor_t;

  // Flavors of random candidate.
  typedef enum int {
    GEN_VALID,
    GEN_BAD_FIELD,
    GEN_BAD_ADDR,
    GEN_BAD_CTRL,
    GEN_NOISE
  } cand_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [63:0]       epoch = '0;
  logic [31:0]       sequence_req = '0;
  logic [7:0]        issuer_tid = '0;
  logic [15:0]       machine_state = '0;
  logic [15:0]       control_word = '0;
  logic [7:0]        wr_cell = '0;
  logic signed [7:0] wr_val = '0;
  logic [63:0]       instruction_id = '0;
  logic [63:0]       read_set_low = '0;
  logic [63:0]       read_set_high = '0;
  logic [63:0]       write_set_low = '0;
  logic [63:0]       write_set_high = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic [18:0]       proj_addr;
  logic [5:0]        phase;
  logic [7:0]        ctrl_digits;
  logic [63:0]       cand_hash;

  descriptor_t pending_descriptors[$];
  int          error_count = 0;
  int          sent_count = 0;
  int          checked_count = 0;
  int          status_seen[4] = '{0, 0, 0, 0};
  int          cycle_count = 0;
  int          rx_hold = 0;       // stall cycles left before the next result is taken
  bit          calm = 1'b0;       // when set, neither side idles

  candidate_descriptor_hasher_core #(
    .CELL_COUNT (CELLS),
    .TRIT_COUNT (TRITS)
  ) dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .epoch              (epoch),
    .sequence_req       (sequence_req),
    .issuer_tid         (issuer_tid),
    .machine_state      (machine_state),
    .control_word       (control_word),
    .wr_cell            (wr_cell),
    .wr_val             (wr_val),
    .instruction_id     (instruction_id),
    .read_set_low       (read_set_low),
    .read_set_high      (read_set_high),
    .write_set_low      (write_set_low),
    .write_set_high     (write_set_high),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .status             (status),
    .proj_addr          (proj_addr),
    .phase              (phase),
    .ctrl_digits        (ctrl_digits),
    .cand_hash          (cand_hash)
  );

  always #2 clk = ~clk;

  // Run guard: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("candidate_descriptor_hasher_core_tb: errors");
      $finish;
    end
  end

  // splitmix64 finalizer, one link of the identity chain.
  function automatic logic [63:0] splitmix_final(input logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * MIX_MUL_A;
    v = v ^ (v >> 27);
    v = v * MIX_MUL_B;
    v = v ^ (v >> 31);
    return v;
  endfunction

  // Expected descriptor for one candidate. Checks run in a fixed order; the
  // first failing one wins and every other field then reads zero.
  function automatic descriptor_t hash_candidate(input candidate_t c);
    descriptor_t d;
    logic [15:0] rest;
    logic [7:0]  value_bias;
    logic [63:0] id;
    bit          value_ok;
    d = '0;
    value_ok = (c.wr_val == 8'hFF) || (c.wr_val == 8'h00) ||
               (c.wr_val == 8'h01);
    if (c.issuer_tid >= THREAD_LIMIT || c.wr_cell >= CELLS || !value_ok)
      d.status = ST_FIELD;
    else if (c.machine_state >= STATE_SPAN)
      d.status = ST_ADDR;
    else if (c.control_word >= CTRL_SPAN)
      d.status = ST_CTRL;
    else
      d.status = ST_OK;
    if (d.status == ST_OK) begin
      d.proj_addr = 19'(32'(c.machine_state) * CTRL_SPAN + 32'(c.control_word));
      d.phase = OP_PHASE[c.machine_state % OPS_PER_CELL];
      // Most significant trit lands in the lowest slot; slots past 4 drop off.
      rest = c.control_word;
      for (int i = TRITS - 1; i >= 0; i--) begin
        if (i < 4)
          d.ctrl_digits[2*i +: 2] = 2'(rest % 3);
        rest = rest / 3;
      end
      value_bias = c.wr_val + 8'd1;
      id = c.epoch;
      id = splitmix_final(id ^ {c.sequence_req, 32'd0});
      id = splitmix_final(id ^ (64'(c.issuer_tid) << 48));
      id = splitmix_final(id ^ (64'(c.machine_state) << 16));
      id = splitmix_final(id ^ (64'(c.control_word) << 8));
      id = splitmix_final(id ^ (64'(c.wr_cell) << 1));
      id = splitmix_final(id ^ 64'(value_bias));
      id = splitmix_final(id ^ c.instruction_id);
      id = splitmix_final(id ^ c.read_set_low ^ c.read_set_high);
      id = splitmix_final(id ^ c.write_set_low ^ c.write_set_high);
      d.cand_hash = id;
    end
    return d;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Idle cycles before a transfer: none in calm stretches, else often none.
  function automatic int idle_draw();
    if (calm || $urandom_range(0, 1) == 0)
      return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic candidate_t make_candidate(input cand_kind_t kind);
    candidate_t c;
    c.epoch          = rand64();
    c.sequence_req   = $urandom;
    c.issuer_tid     = 8'($urandom_range(0, THREAD_LIMIT - 1));
    c.machine_state  = 16'($urandom_range(0, STATE_SPAN - 1));
    c.control_word   = 16'($urandom_range(0, CTRL_SPAN - 1));
    c.wr_cell        = 8'($urandom_range(0, CELLS - 1));
    c.wr_val         = 8'($urandom_range(0, 2)) - 8'd1;
    c.instruction_id = rand64();
    c.read_set_low   = rand64();
    c.read_set_high  = rand64();
    c.write_set_low  = rand64();
    c.write_set_high = rand64();
    case (kind)
      GEN_BAD_FIELD: begin
        case ($urandom_range(0, 2))
          0:       c.issuer_tid = 8'($urandom_range(THREAD_LIMIT, 255));
          1:       c.wr_cell    = 8'($urandom_range(CELLS, 255));
          default: c.wr_val     = 8'($urandom_range(2, 254));
        endcase
        // sometimes let a later check fail too; the field check must still win
        if ($urandom_range(0, 1) == 1)
          c.machine_state = 16'($urandom_range(STATE_SPAN, 65535));
      end
      GEN_BAD_ADDR: begin
        c.machine_state = 16'($urandom_range(STATE_SPAN, 65535));
        if ($urandom_range(0, 1) == 1)
          c.control_word = 16'($urandom_range(CTRL_SPAN, 65535));
      end
      GEN_BAD_CTRL: c.control_word = 16'($urandom_range(CTRL_SPAN, 65535));
      GEN_NOISE: begin
        c.issuer_tid    = 8'($urandom);
        c.machine_state = 16'($urandom);
        c.control_word  = 16'($urandom);
        c.wr_cell       = 8'($urandom);
        c.wr_val        = 8'($urandom);
      end
      default: ;
    endcase
    return c;
  endfunction

  // Present one candidate and hold it until the block takes the transfer.
  // Called and returning on a falling edge.
  task automatic send_candidate(input candidate_t c);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    epoch          <= c.epoch;
    sequence_req   <= c.sequence_req;
    issuer_tid     <= c.issuer_tid;
    machine_state  <= c.machine_state;
    control_word   <= c.control_word;
    wr_cell        <= c.wr_cell;
    wr_val         <= c.wr_val;
    instruction_id <= c.instruction_id;
    read_set_low   <= c.read_set_low;
    read_set_high  <= c.read_set_high;
    write_set_low  <= c.write_set_low;
    write_set_high <= c.write_set_high;
    in_valid       <= 1'b1;
    do
      @(posedge clk);
    while (in_stall);
    pending_descriptors.push_back(hash_candidate(c));
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver: hold stall for the drawn count, then release for one result.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold = rx_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Result checker: every transfer on the output side against the oldest expectation.
  always @(posedge clk) begin
    descriptor_t exp_d;
    if (!rst && out_valid && !out_stall) begin
      if (pending_descriptors.size() == 0) begin
        $error("descriptor with no candidate outstanding: status %0d", status);
        error_count++;
      end else begin
        exp_d = pending_descriptors.pop_front();
        check_field("status", 64'(exp_d.status), 64'(status));
        check_field("proj_addr", 64'(exp_d.proj_addr), 64'(proj_addr));
        check_field("phase", 64'(exp_d.phase), 64'(phase));
        check_field("ctrl_digits", 64'(exp_d.ctrl_digits), 64'(ctrl_digits));
        check_field("cand_hash", exp_d.cand_hash, cand_hash);
        status_seen[exp_d.status]++;
        checked_count++;
      end
      rx_hold = idle_draw();
    end
  end

  // Range edges of every field, valid and just out of range.
  task automatic test_field_extremes();
    candidate_t c;
    c = make_candidate(GEN_VALID);
    c.issuer_tid = '0; c.machine_state = '0; c.control_word = '0;
    c.wr_cell = '0; c.wr_val = 8'h00;
    c.epoch = '0; c.sequence_req = '0; c.instruction_id = '0;
    c.read_set_low = '0; c.read_set_high = '0; c.write_set_low = '0; c.write_set_high = '0;
    send_candidate(c);
    // top of every valid range, all-ones wide words
    c.issuer_tid = 8'(THREAD_LIMIT - 1); c.machine_state = 16'(STATE_SPAN - 1);
    c.control_word = 16'(CTRL_SPAN - 1); c.wr_cell = 8'(CELLS - 1); c.wr_val = 8'h01;
    c.epoch = '1; c.sequence_req = '1; c.instruction_id = '1;
    c.read_set_low = '1; c.read_set_high = '1; c.write_set_low = '1; c.write_set_high = '1;
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.wr_val = 8'hFF;                // -1
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.issuer_tid = 8'(THREAD_LIMIT); // first invalid thread
    send_candidate(c);
    c.issuer_tid = 8'hFF;
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.wr_cell = 8'(CELLS);           // one past the last cell
    send_candidate(c);
    c.wr_cell = 8'hFF;
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.wr_val = 8'h02;
    send_candidate(c);
    c.wr_val = 8'h80;                // -128
    send_candidate(c);
    c.wr_val = 8'h7F;
    send_candidate(c);
    c.wr_val = 8'hFE;                // -2
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.machine_state = 16'(STATE_SPAN);
    send_candidate(c);
    c.machine_state = 16'hFFFF;
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.control_word = 16'(CTRL_SPAN);
    send_candidate(c);
    c.control_word = 16'hFFFF;
    send_candidate(c);
  endtask

  // Several checks failing at once: only the earliest is reported.
  task automatic test_check_priority();
    candidate_t c;
    c = make_candidate(GEN_VALID);
    c.issuer_tid = 8'hC0; c.machine_state = 16'hFFFF; c.control_word = 16'hFFFF;
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.wr_val = 8'h55; c.control_word = 16'hFFFF;
    send_candidate(c);
    c = make_candidate(GEN_VALID);
    c.machine_state = 16'(STATE_SPAN); c.control_word = 16'(CTRL_SPAN);
    send_candidate(c);
    c = make_candidate(GEN_NOISE);
    c.issuer_tid = 8'hFF; c.wr_cell = 8'hFF; c.wr_val = 8'h80;
    c.machine_state = 16'hFFFF; c.control_word = 16'hFFFF;
    send_candidate(c);
  endtask

  // Random stream: mostly valid candidates so the identity chain is
  // exercised hard, the rest spread over each failing check and raw noise.
  task automatic test_random_stream(input int count);
    int         pick;
    cand_kind_t kind;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      kind = GEN_VALID;
      else if (pick < 80) kind = GEN_BAD_FIELD;
      else if (pick < 87) kind = GEN_BAD_ADDR;
      else if (pick < 94) kind = GEN_BAD_CTRL;
      else                kind = GEN_NOISE;
      send_candidate(make_candidate(kind));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_field_extremes();
    test_check_priority();
    test_random_stream(300);
    // back-to-back stretch: full rate in, no stall out
    calm = 1'b1;
    test_random_stream(200);
    calm = 1'b0;
    test_random_stream(300);
    in_valid <= 1'b0;

    while (pending_descriptors.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Sent %0d candidates, checked %0d descriptors in %0d cycles.",
             sent_count, checked_count, cycle_count);
    $display("Status mix: ok %0d, field %0d, address %0d, control %0d.",
             status_seen[ST_OK], status_seen[ST_FIELD], status_seen[ST_ADDR],
             status_seen[ST_CTRL]);
    if (error_count == 0)
      $display("candidate_descriptor_hasher_core_tb: clean");
    else
      $display("candidate_descriptor_hasher_core_tb: errors");
    $finish;
  end

endmodule
